FILE: design/ncrs_pkg.sv
`default_nettype none
package ncrs_pkg;
   localparam int unsigned XW        = 32;  // Q16.16 value
   localparam int unsigned TOL_W     = 31;
   localparam int unsigned LIM_W     = 8;
   localparam int unsigned CNT_W     = 9;
   localparam int unsigned SQ_W      = 47;  // x^2 in Q16.16, never negative
   localparam int unsigned DEN_W     = 49;  // |f'(x)|
   localparam int unsigned NUM_W     = 63;  // |f(x)|
   localparam int unsigned QUO_W     = 40;  // quotient bits below the cap
   localparam int unsigned QSAT_SH   = 24;  // integer quotient at or above 2^24 saturates
   localparam int unsigned LIMIT_MAX_DEF = 255;
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ITER_LIMIT = 2'd1;
   localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;
   localparam logic [LIM_W-1:0] LIM_RESET = 8'd20;
   localparam logic signed [63:0] F_CONST = 64'sd2621440;  // 40.0 in Q16.16
   localparam int unsigned RSP_W     = 80;
endpackage
`default_nettype wire

FILE: design/newton_cubic_root_solver_unit.sv
// Each request runs N Newton steps (none when f'(x0) is zero, else 1 .. max(limit, 1));
// S_FIN then holds the result while the previous one still waits on rsp_tready.
// Each step runs three passes of one shared 32x32 multiplier, a sum, a test and a
// restoring divider that stops early once the quotient saturates.
// A new request is taken only after the last one is finished; req_tready is high only while idle.
// Reset: synchronous, active high; tolerance returns to 66, iteration limit to 20.
`default_nettype none
module newton_cubic_root_solver_unit #(
   parameter int unsigned LIMIT_MAX = ncrs_pkg::LIMIT_MAX_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [ncrs_pkg::XW-1:0]            req_tdata,  // start_value
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // root_estimate[31:0], residual[63:32], pass_count[72:64], converged[73],
   // limit_reached[74], divide_fault[75], zero pad[79:76]
   output logic [ncrs_pkg::RSP_W-1:0]              rsp_tdata,
   input  wire logic                               csr_wen,
   input  wire logic [ncrs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ncrs_pkg::TOL_W-1:0]         csr_wdata
);
   import ncrs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SQ, S_HI, S_LO, S_SUM, S_TEST, S_DSET, S_DIV, S_UPD, S_FIN
   } state_type;

   localparam int unsigned LW = 17;
   localparam logic [LW-1:0] LIM_CAP = LW'(LIMIT_MAX);
   localparam logic [5:0] DIV_STEPS = 6'(QUO_W);

   state_type                state_ff, state_in;
   logic [TOL_W-1:0]         tol_ff, tol_in;
   logic [LIM_W-1:0]         lim_ff, lim_in;
   logic signed [XW-1:0]     x_ff, x_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic signed [63:0]       hix_ff, hix_in, lox_ff, lox_in, f_ff, f_in, df_ff, df_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     first_ff, first_in, fault_ff, fault_in;
   logic [DEN_W-1:0]         b_ff, b_in, rem_ff, rem_in;
   logic [NUM_W-1:0]         a_ff, a_in;
   logic [QUO_W-1:0]         sh_ff, sh_in;
   logic                     neg_ff, neg_in, qsat_ff, qsat_in;
   logic [5:0]               dcnt_ff, dcnt_in;
   logic                     ov_ff, ov_in;
   logic [RSP_W-1:0]         out_ff, out_in;

   logic signed [XW-1:0]     mul_a, mul_b;
   logic signed [63:0]       prod;
   logic [63:0]              afx;
   logic                     conv;
   logic [LW-1:0]            lim_eff;
   logic [CNT_W-1:0]         cnt_nx;
   logic [DEN_W:0]           trial;
   logic                     ge;
   logic signed [42:0]       qs, diff;
   logic [QUO_W:0]           mag;
   logic signed [XW-1:0]     res_sat;

   assign prod    = mul_a * mul_b;
   assign afx     = f_ff[63] ? 64'(-f_ff) : 64'(f_ff);
   assign conv    = afx <= {33'd0, tol_ff};
   assign lim_eff = ({9'd0, lim_ff} > LIM_CAP) ? LIM_CAP : {9'd0, lim_ff};
   assign cnt_nx  = cnt_ff + 9'd1;
   assign trial   = {rem_ff, sh_ff[QUO_W-1]};
   assign ge      = trial >= {1'b0, b_ff};
   assign mag     = qsat_ff ? {1'b1, {QUO_W{1'b0}}} : {1'b0, sh_ff};
   assign qs      = neg_ff ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
   assign diff    = {{11{x_ff[XW-1]}}, x_ff} - qs;
   assign res_sat = (f_ff > 64'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                    (f_ff < -64'sh80000000) ? 32'sh80000000 : f_ff[XW-1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;

   always_comb begin
      mul_a = x_ff;
      mul_b = x_ff;
      case (state_ff)
         S_HI:    mul_a = $signed({1'b0, sq_ff[SQ_W-1:16]});
         S_LO:    mul_a = $signed({16'd0, sq_ff[15:0]});
         default: mul_a = x_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      tol_in   = tol_ff;
      lim_in   = lim_ff;
      x_in     = x_ff;
      sq_in    = sq_ff;
      hix_in   = hix_ff;
      lox_in   = lox_ff;
      f_in     = f_ff;
      df_in    = df_ff;
      cnt_in   = cnt_ff;
      first_in = first_ff;
      fault_in = fault_ff;
      b_in     = b_ff;
      rem_in   = rem_ff;
      a_in     = a_ff;
      sh_in    = sh_ff;
      neg_in   = neg_ff;
      qsat_in  = qsat_ff;
      dcnt_in  = dcnt_ff;
      ov_in    = ov_ff & ~rsp_tready;
      out_in   = out_ff;

      if (csr_wen) begin
         if (csr_index == CSR_TOLERANCE) tol_in = csr_wdata;
         else if (csr_index == CSR_ITER_LIMIT) lim_in = csr_wdata[LIM_W-1:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               x_in     = $signed(req_tdata);
               cnt_in   = 9'd1;
               first_in = 1'b1;
               fault_in = 1'b0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            sq_in    = prod[SQ_W+15:16];
            state_in = S_HI;
         end
         S_HI: begin
            hix_in   = prod;
            state_in = S_LO;
         end
         S_LO: begin
            lox_in   = prod >>> 16;
            state_in = S_SUM;
         end
         S_SUM: begin
            f_in  = hix_ff + lox_ff + 64'($signed({17'd0, sq_ff})) * 64'sd3
                    + 64'($signed({18'd0, sq_ff[SQ_W-1:1]})) - F_CONST;
            df_in = 64'($signed({17'd0, sq_ff})) * 64'sd3
                    + 64'(x_ff) * 64'sd7;
            state_in = S_TEST;
         end
         S_TEST: begin
            first_in = 1'b0;
            a_in     = afx[NUM_W-1:0];
            b_in     = df_ff[63] ? DEN_W'(-df_ff) : DEN_W'(df_ff);
            neg_in   = f_ff[63] ^ df_ff[63];
            if (!first_ff && conv) begin
               state_in = S_FIN;
            end else if (!first_ff && ({8'd0, cnt_nx} > lim_eff)) begin
               cnt_in   = cnt_nx;
               state_in = S_FIN;
            end else begin
               if (!first_ff) cnt_in = cnt_nx;
               if (df_ff == 64'sd0) begin
                  fault_in = 1'b1;
                  state_in = S_FIN;
               end else begin
                  state_in = S_DSET;
               end
            end
         end
         S_DSET: begin
            qsat_in  = {10'd0, a_ff} >= {b_ff, 24'd0};
            rem_in   = {{(DEN_W-(NUM_W-QSAT_SH)){1'b0}}, a_ff[NUM_W-1:QSAT_SH]};
            sh_in    = {a_ff[QSAT_SH-1:0], 16'd0};
            dcnt_in  = DIV_STEPS;
            state_in = S_DIV;
         end
         S_DIV: begin
            // restoring divide, one quotient bit per cycle
            rem_in  = ge ? trial[DEN_W-1:0] - b_ff : trial[DEN_W-1:0];
            sh_in   = {sh_ff[QUO_W-2:0], ge};
            dcnt_in = dcnt_ff - 6'd1;
            if (qsat_ff || dcnt_ff == 6'd1) state_in = S_UPD;
         end
         S_UPD: begin
            x_in = (diff > 43'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                   (diff < -43'sh80000000) ? 32'sh80000000 : diff[XW-1:0];
            dcnt_in  = 6'd0;
            state_in = S_SQ;
         end
         S_FIN: begin
            if (!ov_ff || rsp_tready) begin
               out_in = {4'd0, fault_ff, ({8'd0, cnt_ff} >= lim_eff), conv, cnt_ff,
                         res_sat, x_ff};
               ov_in    = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tol_ff   <= TOL_RESET;
         lim_ff   <= LIM_RESET;
         ov_ff    <= 1'b0;
         dcnt_ff  <= 6'd0;
         first_ff <= 1'b0;
         fault_ff <= 1'b0;
         cnt_ff   <= 9'd1;
      end else begin
         state_ff <= state_in;
         tol_ff   <= tol_in;
         lim_ff   <= lim_in;
         ov_ff    <= ov_in;
         dcnt_ff  <= dcnt_in;
         first_ff <= first_in;
         fault_ff <= fault_in;
         cnt_ff   <= cnt_in;
      end
      x_ff    <= x_in;
      sq_ff   <= sq_in;
      hix_ff  <= hix_in;
      lox_ff  <= lox_in;
      f_ff    <= f_in;
      df_ff   <= df_in;
      b_ff    <= b_in;
      rem_ff  <= rem_in;
      a_ff    <= a_in;
      sh_ff   <= sh_in;
      neg_ff  <= neg_in;
      qsat_ff <= qsat_in;
      out_ff  <= out_in;
   end

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 9'd256 && cnt_ff != 9'd0) else $error("pass count out of range");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (dcnt_ff != 6'd0)) else $error("divider overran");
   a_fin_to_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && state_in == S_IDLE) |=> rsp_tvalid)
      else $error("result lost");
endmodule
`default_nettype wire

FILE: tb/newton_cubic_root_solver_checker.sv
`timescale 1ns / 1ps
module newton_cubic_root_solver_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   input  wire logic [ncrs_pkg::XW-1:0]           req_tdata,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [ncrs_pkg::RSP_W-1:0]        rsp_tdata,
   input  wire logic                              csr_wen,
   input  wire logic [ncrs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ncrs_pkg::TOL_W-1:0]        csr_wdata,
   output int                                     fail_count,
   output int                                     pending
);
   import ncrs_pkg::*;

   localparam int unsigned SOLVE_LIMIT_MAX = LIMIT_MAX_DEF;

   typedef struct packed {
      logic [31:0] root;
      logic [31:0] resid;
      logic [8:0]  count;
      logic        conv;
      logic        lim;
      logic        fault;
   } solution_type;

   logic [TOL_W-1:0] tol_reg;
   logic [LIM_W-1:0] lim_reg;
   solution_type     solutions_due[$];

   function automatic longint sat_q32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint sq_q(longint x);
      return (x * x) >>> 16;
   endfunction

   function automatic longint cubic_f(longint x);
      longint sq, hi, lo, cube;
      sq   = sq_q(x);
      hi   = sq >>> 16;
      lo   = sq & 64'hFFFF;
      cube = hi * x + ((lo * x) >>> 16);  // arithmetic shift floors
      return cube + 3 * sq + (sq >>> 1) - 40 * 65536;
   endfunction

   function automatic longint cubic_df(longint x);
      return 3 * sq_q(x) + 7 * x;
   endfunction

   // Q16.16 quotient, truncated toward zero, magnitude capped at 2^40
   function automatic longint newton_quot(longint num, longint den);
      longint unsigned a, b, q1, r, mag;
      a = (num < 0) ? -num : num;
      b = (den < 0) ? -den : den;
      q1 = a / b;
      r  = a % b;
      if (q1 >= (64'd1 << 24)) begin
         mag = 64'd1 << 40;
      end else begin
         mag = q1 << 16;
         for (int i = 15; i >= 0; i--) begin
            r = r << 1;
            if (r >= b) begin
               r = r - b;
               mag = mag | (64'd1 << i);
            end
         end
         if (mag > (64'd1 << 40)) mag = 64'd1 << 40;
      end
      if ((num < 0) != (den < 0)) return -longint'(mag);
      return longint'(mag);
   endfunction

   function automatic solution_type solve_cubic(logic signed [31:0] x0);
      longint x, fx, df, afx, tol;
      longint unsigned lim, cnt;
      logic fault;
      solution_type s;
      x     = x0;
      tol   = tol_reg;
      lim   = lim_reg;
      cnt   = 1;
      fault = 1'b0;
      fx    = cubic_f(x);
      if (lim > SOLVE_LIMIT_MAX) lim = SOLVE_LIMIT_MAX;
      forever begin
         df = cubic_df(x);
         if (df == 0) begin
            fault = 1'b1;
            break;
         end
         x   = sat_q32(x - newton_quot(fx, df));
         fx  = cubic_f(x);
         afx = (fx < 0) ? -fx : fx;
         if (afx <= tol) break;
         cnt++;
         if (cnt > lim) break;
      end
      afx     = (fx < 0) ? -fx : fx;
      s.root  = x[31:0];
      s.resid = 32'(sat_q32(fx));
      s.count = cnt[8:0];
      s.conv  = (afx <= tol);
      s.lim   = (cnt >= lim);
      s.fault = fault;
      return s;
   endfunction

   always @(posedge clock) begin
      solution_type want, got;
      if (reset) begin
         tol_reg <= TOL_RESET;
         lim_reg <= LIM_RESET;
         solutions_due.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_wen) begin
            if (csr_index == CSR_TOLERANCE) tol_reg <= csr_wdata;
            else if (csr_index == CSR_ITER_LIMIT) lim_reg <= csr_wdata[LIM_W-1:0];
         end
         if (req_tvalid && req_tready) solutions_due.push_back(solve_cubic(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[72:64],
                   rsp_tdata[73], rsp_tdata[74], rsp_tdata[75]};
            if (solutions_due.size() == 0) begin
               $error("unexpected result item %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = solutions_due.pop_front();
               if (want != got) begin
                  fail_count <= fail_count + 1;
                  if (want.root != got.root)
                     $error("root_estimate: expected %h, actual %h", want.root, got.root);
                  if (want.resid != got.resid)
                     $error("residual: expected %h, actual %h", want.resid, got.resid);
                  if (want.count != got.count)
                     $error("pass_count: expected %0d, actual %0d", want.count, got.count);
                  if (want.conv != got.conv)
                     $error("converged: expected %0d, actual %0d", want.conv, got.conv);
                  if (want.lim != got.lim)
                     $error("limit_reached: expected %0d, actual %0d", want.lim, got.lim);
                  if (want.fault != got.fault)
                     $error("divide_fault: expected %0d, actual %0d", want.fault, got.fault);
               end
            end
         end
         pending <= solutions_due.size();
      end
   end
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import ncrs_pkg::*;

   localparam int STALL_LIMIT = 100000;
   localparam int HOLD_CYCLES = 6000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [XW-1:0]        req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TOL_W-1:0]     csr_wdata = '0;
   int                   fail_count;
   int                   pending;
   int                   cyc = 0;
   int                   idle_cycles = 0;
   int                   tail;
   logic                 hold_armed = 1'b0;
   int                   hold_cnt = 0;

   always #6 clock = ~clock;

   newton_cubic_root_solver_unit dut (.*);
   newton_cubic_root_solver_checker chk (.*);

   always @(posedge clock) cyc <= cyc + 1;

   // receiver: random stalls, one long hold-off so the block backs up, then a calm stretch
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_armed && hold_cnt < HOLD_CYCLES) begin
         rsp_tready <= 1'b0;
         hold_cnt   <= hold_cnt + 1;
      end
      else if (cyc >= 60000 && cyc < 110000) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(99) >= 8);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_start(logic [31:0] v);
      if (cyc >= 60000 && cyc < 110000) begin
      end else if ($urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic set_regs(logic [TOL_W-1:0] tol, logic [LIM_W-1:0] lim);
      req_tvalid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_wen <= 1'b1; csr_index <= CSR_TOLERANCE; csr_wdata <= tol;
      @(posedge clock);
      csr_index <= CSR_ITER_LIMIT; csr_wdata <= TOL_W'(lim);
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_start();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 40) return $urandom;
      if (pick < 80) return 32'(int'($urandom_range(1310720)) - 655360);
      if (pick < 90) return 32'(183500 + int'($urandom_range(8192)) - 4096);
      if (pick < 95) return 32'(-152917 + int'($urandom_range(512)) - 256);
      return 32'd0;
   endfunction

   function automatic logic [TOL_W-1:0] rand_tol();
      case ($urandom_range(4))
         0: return '0;
         1: return TOL_RESET;
         2: return TOL_W'($urandom_range(4096));
         3: return TOL_W'($urandom);
         default: return {TOL_W{1'b1}};
      endcase
   endfunction

   initial begin
      logic [31:0] directed [$];
      logic [LIM_W-1:0] lim;
      int n;
      directed = '{32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h0002_8000, 32'h0002_CCCC,
                   32'hFFFD_AAAB, 32'h0000_0001, 32'hFFFF_FFFF,
                   32'h0100_0000, 32'hFF00_0000};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_start(directed[i]);
      set_regs({TOL_W{1'b1}}, 8'd0);         // widest tolerance, limit of zero
      foreach (directed[i]) if (i < 5) send_start(directed[i]);
      set_regs('0, 8'd255);                  // never converges, longest runs
      for (int i = 0; i < 3; i++) send_start(rand_start());
      set_regs(31'd1, 8'd1);
      for (int i = 0; i < 4; i++) send_start(directed[i + 3]);
      set_regs(TOL_RESET, LIM_RESET);

      n = 0;
      while (n < 450) begin
         lim = ($urandom_range(9) == 0) ? LIM_W'($urandom_range(255, 100))
                                        : LIM_W'($urandom_range(40));
         set_regs(rand_tol(), lim);
         // short runs: the hold-off backs the block up within a few items
         if (lim <= 60) hold_armed <= 1'b1;
         for (int i = 0; i < ((lim > 60) ? 5 : 50); i++) begin
            send_start(rand_start());
            n++;
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      @(posedge clock);
      tail = 0;
      while (pending != 0 && tail < 500000) begin
         @(posedge clock);
         tail++;
      end
      repeat (60) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
